// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker.
// CNE_ASSERT: checked on the rising clock edge, off while reset is low.
// CNE_ASSERT_ALWAYS: checked on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CNE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cne assertion failed");

`define CNE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cne assertion failed");

`endif

// ===== rtl/cne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_pkg
// Constants, types and helper functions of the carrier-to-noise estimator.
// ----------------------------------------------------------------------------
package cne_pkg;

  localparam int unsigned FRACTION_BITS_DEF   = 8;
  localparam int unsigned LOG_TABLE_DEPTH_DEF = 256;

  // 5505024 = 1.3125 * 2^22: exponent and mantissa fraction of the numerator
  localparam int unsigned REF_EXP  = 22;
  localparam logic [22:0] REF_FRAC = 23'h280000;

  // 10*log10(2) in Q.16
  localparam logic signed [19:0] TEN_LOG10_2_Q16 = 20'sd197283;

  // Quartic coefficients in Q.28
  localparam logic signed [31:0] C4_Q28 = 32'sd6442;
  localparam logic signed [31:0] C3_Q28 = 32'sd429497;
  localparam logic signed [31:0] C2_Q28 = 32'sd10683731;
  localparam logic signed [31:0] C1_Q28 = 32'sd147397909;
  localparam logic signed [31:0] C0_Q28 = 32'sd831210390;

  // Satellite table interpolation and the divide by 409600 = 25 * 2^14
  localparam logic [7:0]  SAT_CLIP_HI     = 8'h10;
  localparam logic [7:0]  SAT_CLIP_LO     = 8'hB0;
  localparam logic [23:0] SAT_TOP         = 24'd9859072;  // 2407 * 4096
  localparam logic [23:0] SAT_LVL3        = 24'd12288000; // 3000 * 4096
  localparam logic [23:0] SAT_LVL2        = 24'd6144000;  // 1500 * 4096
  localparam logic [17:0] SAT_ROUND       = 18'd204800;
  localparam int unsigned SAT_DIV_SHIFT   = 14;
  localparam logic [4:0]  SAT_DIV_FACTOR  = 5'd25;
  localparam logic [25:0] SAT_RECIP       = 26'd42949672; // floor(2^30 / 25)
  localparam int unsigned SAT_RECIP_SHIFT = 30;

  typedef enum logic {
    REG_CHANNEL_KIND = 1'b0,
    REG_LEVEL_ENABLE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    LEVEL_OFF  = 2'd0,
    LEVEL_LOW  = 2'd1,
    LEVEL_MID  = 2'd2,
    LEVEL_HIGH = 2'd3
  } level_e;

  typedef struct packed {
    logic        kind;
    logic        len;
    logic        zero;
    logic [15:0] scnr;
    level_e      slvl;
  } ctl_t;

  // Satellite dB table in hundredths of a dB, indexed by nibble.
  function automatic logic [11:0] sat_tab(input logic [3:0] n);
    logic [11:0] v;
    case (n)
      4'd0:    v = 12'd2407;
      4'd1:    v = 12'd2407;
      4'd2:    v = 12'd1861;
      4'd3:    v = 12'd1521;
      4'd4:    v = 12'd1250;
      4'd5:    v = 12'd1019;
      4'd6:    v = 12'd814;
      4'd7:    v = 12'd627;
      4'd8:    v = 12'd455;
      4'd9:    v = 12'd294;
      4'd10:   v = 12'd142;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  // log2 of x0 / 2^30 (x0 in [2^30, 2^31)) to 24 fraction bits by squaring.
  // Evaluated at elaboration only.
  function automatic logic [23:0] log_entry(input logic [63:0] x0);
    logic [63:0] x;
    logic [23:0] r;
    x = x0;
    r = '0;
    for (int k = 0; k < 24; k++) begin
      x = (x * x) >> 30;
      r = {r[22:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  // Round to nearest, ties away from zero, then drop n bits.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned n);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sd32767;
    end else if (v < -64'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/carrier_to_noise_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carrier_to_noise_estimator
// Raw tuner reading in, carrier-to-noise estimate (signed Q8.8 dB) and a
// quality level out, through a fifteen-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one raw_signal beat per clock cycle and returns one result
// beat per reading, in order. A reading accepted at one edge moves through
// the pipeline to the result port and leaves on the next edge at which the
// output side is ready. All stages advance together: while the output beat
// is held, the whole pipeline holds and in_ready_o drops; otherwise a beat
// enters in every cycle. Terrestrial mode (channel_kind = 0) finds the
// leading one, looks up log2 of the mantissa in a constant table of
// LOG_TABLE_DEPTH entries, forms P = 10*log10(5505024/reading) in Q.16 and
// runs the quartic by Horner, one multiply stage and one round-and-add stage
// per Horner step. A zero reading gives 32767 and level 3. Satellite mode
// (channel_kind = 1) interpolates the dB table by the upper nibble of bits
// 15:8 with the low 12 bits as the mix fraction, clips at 0x10xx and 0xB0xx,
// and divides by 409600 with a reciprocal multiply and one correction step.
// quality_level_o is 0 unless level_enable is set. Write channel_kind at
// byte address 0 and level_enable at byte address 4, bit 0, only while the
// pipeline is empty; each beat keeps the settings seen when it entered.
module carrier_to_noise_estimator #(
  parameter int unsigned FRACTION_BITS   = cne_pkg::FRACTION_BITS_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = cne_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // reading channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] raw_signal_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] cnr_q8_o,
  output logic [1:0]  quality_level_o
);
  import cne_pkg::*;

  localparam int unsigned NST       = 15;
  localparam int unsigned IDXW      = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned SHIFT_OUT = 28 - FRACTION_BITS;
  localparam int unsigned SXW       = 25 + FRACTION_BITS;
  localparam int unsigned SYW       = SXW - SAT_DIV_SHIFT;
  localparam int unsigned SMW       = SYW + 26;

  // log2(5505024) in Q.24 through the same table as the reading
  localparam logic [63:0] REF_IDX = (64'(REF_FRAC) * LOG_TABLE_DEPTH) >> 23;
  localparam logic [63:0] REF_X0  = (64'd1 << 30) + ((REF_IDX << 30) / LOG_TABLE_DEPTH);
  localparam logic [29:0] LOG_REF = 30'((64'(REF_EXP) << 24) + 64'(log_entry(REF_X0)));

  localparam logic signed [43:0] TLVL3 = 44'(64'd30 << 28);
  localparam logic signed [43:0] TLVL2 = 44'(64'd15 << 28);

  // ---------------------------------------------------------------- config
  logic kind_q, len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b1;
      len_q  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[2]))
        REG_CHANNEL_KIND: kind_q <= pwdata[0];
        REG_LEVEL_ENABLE: len_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_CHANNEL_KIND: prdata = {31'd0, kind_q};
      REG_LEVEL_ENABLE: prdata = {31'd0, len_q};
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ------------------------------------------------------------ log2 table
  logic [23:0] log_rom [LOG_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_log_rom
    localparam logic [63:0] X0 = (64'd1 << 30) + ((64'(g) << 30) / LOG_TABLE_DEPTH);
    assign log_rom[g] = log_entry(X0);
  end

  // -------------------------------------------------------- pipeline state
  logic        vld_q [NST];
  ctl_t        ctl_q [NST];
  logic        en;

  // the whole pipe advances unless the output beat is held
  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  // stage payloads
  logic [23:0]            raw0_q, raw1_q;
  logic [4:0]             e1_q, e2_q;
  logic [24:0]            pa1_q, pb1_q;
  logic                   chi1_q, clo1_q;
  logic [IDXW-1:0]        idx2_q;
  logic [23:0]            v2_q, v3_q;
  logic signed [29:0]     d3_q;
  logic [SYW-1:0]         y3_q;
  logic [SMW-1:0]         m3_q;
  logic signed [49:0]     pr4_q;
  logic signed [24:0]     p_q [5:11];
  logic signed [39:0]     mp6_q;
  logic signed [33:0]     a7_q, a9_q, a11_q;
  logic signed [58:0]     m8_q, m10_q, m12_q;
  logic signed [43:0]     a13_q;
  logic signed [15:0]     cnr14_q;
  logic [1:0]             lvl14_q;

  // stage 1: leading one of the reading, satellite products
  logic [4:0]  e1_d;
  logic [7:0]  hi1;
  logic [3:0]  nib1;
  logic [11:0] frc1;
  logic [24:0] pa1_d, pb1_d;

  always_comb begin
    e1_d = '0;
    for (int i = 0; i < 24; i++) begin
      if (raw0_q[i]) begin
        e1_d = 5'(i);
      end
    end
    hi1   = raw0_q[15:8];
    nib1  = hi1[7:4];
    frc1  = raw0_q[11:0];
    pa1_d = 25'(sat_tab(nib1)) * 25'(13'd4096 - {1'b0, frc1});
    pb1_d = 25'(sat_tab(4'(nib1 + 4'd1))) * 25'(frc1);
  end

  // stage 2: normalize, table index; blend satellite value
  logic [22:0]      frac2;
  logic [22+IDXW:0] fprod2;
  logic [23:0]      v2_d;

  always_comb begin
    frac2  = 23'(raw1_q << (5'd23 - e1_q));
    fprod2 = (23 + IDXW)'(frac2) * (23 + IDXW)'(LOG_TABLE_DEPTH);
    if (chi1_q) begin
      v2_d = SAT_TOP;
    end else if (clo1_q) begin
      v2_d = '0;
    end else begin
      v2_d = 24'(pa1_q + pb1_q);
    end
  end

  // stage 3: d = log2(ref) - log2(reading); reciprocal multiply
  logic signed [29:0] d3_d;
  logic [SXW-1:0]     x3;
  logic [SYW-1:0]     y3_d;

  always_comb begin
    d3_d = $signed(LOG_REF - 30'({e2_q, log_rom[idx2_q]}));
    x3   = (SXW'(v2_q) << FRACTION_BITS) + SXW'(SAT_ROUND);
    y3_d = x3[SXW-1:SAT_DIV_SHIFT];
  end

  // stage 4: scale to dB; finish the satellite divide
  logic [SYW-1:0] q4, r4, q4c;
  ctl_t           ctl4;

  always_comb begin
    q4   = SYW'(m3_q >> SAT_RECIP_SHIFT);
    r4   = y3_q - SYW'(q4 * SYW'(SAT_DIV_FACTOR));
    q4c  = (r4 >= SYW'(SAT_DIV_FACTOR)) ? SYW'(q4 + SYW'(1)) : q4;
    ctl4 = ctl_q[3];
    ctl4.scnr = (q4c > SYW'(32767)) ? 16'd32767 : 16'(q4c);
    if (v3_q >= SAT_LVL3) begin
      ctl4.slvl = LEVEL_HIGH;
    end else if (v3_q >= SAT_LVL2) begin
      ctl4.slvl = LEVEL_MID;
    end else begin
      ctl4.slvl = LEVEL_LOW;
    end
  end

  // stage 14: pick the mode, round, saturate, classify
  logic signed [15:0] cnr14_d;
  logic [1:0]         lvl14_d;
  level_e             tlvl;

  always_comb begin
    if (a13_q >= TLVL3) begin
      tlvl = LEVEL_HIGH;
    end else if (a13_q >= TLVL2) begin
      tlvl = LEVEL_MID;
    end else begin
      tlvl = LEVEL_LOW;
    end
    if (ctl_q[13].kind) begin
      cnr14_d = $signed(ctl_q[13].scnr);
      lvl14_d = ctl_q[13].slvl;
    end else if (ctl_q[13].zero) begin
      cnr14_d = 16'sd32767;
      lvl14_d = LEVEL_HIGH;
    end else begin
      cnr14_d = sat16(rnd_shift(64'(a13_q), SHIFT_OUT));
      lvl14_d = tlvl;
    end
    if (!ctl_q[13].len) begin
      lvl14_d = LEVEL_OFF;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // payload: hold on stall, advance otherwise
  always_ff @(posedge clk_i) begin
    if (en) begin
      raw0_q     <= raw_signal_i;
      ctl_q[0]   <= '{kind: kind_q, len: len_q, zero: (raw_signal_i == 24'd0),
                      scnr: 16'd0, slvl: LEVEL_OFF};
      // stage 4 picks up the satellite result
      for (int k = 1; k < NST; k++) begin
        ctl_q[k] <= (k == 4) ? ctl4 : ctl_q[k-1];
      end

      raw1_q <= raw0_q;
      e1_q   <= e1_d;
      pa1_q  <= pa1_d;
      pb1_q  <= pb1_d;
      chi1_q <= (hi1 <= SAT_CLIP_HI);
      clo1_q <= (hi1 >= SAT_CLIP_LO);

      e2_q   <= e1_q;
      idx2_q <= fprod2[22+IDXW:23];
      v2_q   <= v2_d;

      d3_q <= d3_d;
      y3_q <= y3_d;
      m3_q <= SMW'(y3_d) * SMW'(SAT_RECIP);
      v3_q <= v2_q;

      pr4_q <= 50'(d3_q) * 50'(TEN_LOG10_2_Q16);
      p_q[5] <= 25'(rnd_shift(64'(pr4_q), 24));
      for (int k = 6; k <= 11; k++) begin
        p_q[k] <= p_q[k-1];
      end

      mp6_q <= 40'(p_q[5]) * 40'(C4_Q28);
      a7_q  <= 34'(rnd_shift(64'(mp6_q), 16) - 64'(C3_Q28));
      m8_q  <= 59'(a7_q) * 59'(p_q[7]);
      a9_q  <= 34'(rnd_shift(64'(m8_q), 16) + 64'(C2_Q28));
      m10_q <= 59'(a9_q) * 59'(p_q[9]);
      a11_q <= 34'(rnd_shift(64'(m10_q), 16) + 64'(C1_Q28));
      m12_q <= 59'(a11_q) * 59'(p_q[11]);
      a13_q <= 44'(rnd_shift(64'(m12_q), 16) + 64'(C0_Q28));

      cnr14_q <= cnr14_d;
      lvl14_q <= lvl14_d;
    end
  end

  assign cnr_q8_o        = cnr14_q;
  assign quality_level_o = lvl14_q;

endmodule

// ===== rtl/cne_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_port_checker
// Port-level checks of the carrier-to-noise estimator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cne_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] cnr_q8_o,
  input logic [1:0]  quality_level_o
);

  // a held result beat keeps its payload
  `CNE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(cnr_q8_o) && $stable(quality_level_o))

  // the input side stalls exactly when the output beat is held
  `CNE_ASSERT(a_in_ready, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))

  // nothing comes out of reset
  `CNE_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind carrier_to_noise_estimator cne_port_checker u_cne_checker (.*);

// ===== sim/cne_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_checker
// Watches both channels of the estimator, predicts each result and compares.
// ----------------------------------------------------------------------------
module cne_checker
  import cne_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               kind_i,
  input  logic               lvl_en_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [23:0]        raw_signal_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] cnr_q8_i,
  input  logic [1:0]         quality_level_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [15:0] cnr;
    logic [1:0]         lvl;
  } estimate_t;

  estimate_t   estimates_q[$];
  logic [23:0] log2_rom[256];

  initial begin
    logic [63:0] x;
    logic [23:0] r;
    for (int i = 0; i < 256; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / 256);
      r = '0;
      for (int k = 0; k < 24; k++) begin
        x = (x * x) >> 30;
        r = {r[22:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          r[0] = 1'b1;
        end
      end
      log2_rom[i] = r;
    end
  end

  function automatic longint log2_fix(input logic [23:0] v);
    int e;
    logic [63:0] fr;
    e = 23;
    while (e > 0 && v[e] == 1'b0) e--;
    fr = (64'(v) << (23 - e)) & 64'h7FFFFF;
    return (longint'(e) <<< 24) + longint'(log2_rom[(fr * 256) >> 23]);
  endfunction

  function automatic longint round_drop(input longint v, input int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic estimate_t estimate(input logic [23:0] raw, input logic kind,
                                         input logic en);
    estimate_t e;
    longint p, acc, d, v, f, lo, hi_t;
    logic [7:0] hi;
    logic [3:0] n;
    if (!kind) begin
      if (raw == 0) begin
        e.cnr = 16'sd32767;
        e.lvl = LEVEL_HIGH;
      end else begin
        d   = log2_fix(24'd5505024) - log2_fix(raw);
        p   = round_drop(d * 197283, 24);
        acc = 6442;
        acc = round_drop(acc * p, 16) - 429497;
        acc = round_drop(acc * p, 16) + 10683731;
        acc = round_drop(acc * p, 16) + 147397909;
        acc = round_drop(acc * p, 16) + 831210390;
        e.cnr = clamp16(round_drop(acc, 20));
        if (acc >= (longint'(30) <<< 28)) e.lvl = LEVEL_HIGH;
        else if (acc >= (longint'(15) <<< 28)) e.lvl = LEVEL_MID;
        else e.lvl = LEVEL_LOW;
      end
    end else begin
      hi = raw[15:8];
      if (hi <= 8'h10) begin
        v = 2407 * 4096;
      end else if (hi >= 8'hB0) begin
        v = 0;
      end else begin
        n    = hi[7:4];
        f    = raw[11:0];
        lo   = sat_tab(n);
        hi_t = sat_tab(n + 4'd1);
        v    = lo * (4096 - f) + hi_t * f;
      end
      e.cnr = clamp16((v * 256 + 204800) / 409600);
      if (v >= 3000 * 4096) e.lvl = LEVEL_HIGH;
      else if (v >= 1500 * 4096) e.lvl = LEVEL_MID;
      else e.lvl = LEVEL_LOW;
    end
    if (!en) e.lvl = LEVEL_OFF;
    return e;
  endfunction

  assign pending_o = estimates_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        estimates_q.push_back(estimate(raw_signal_i, kind_i, lvl_en_i));
      if (out_valid_i && out_ready_i) begin
        if (estimates_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result beat cnr=%0d", cnr_q8_i);
        end else begin
          want = estimates_q.pop_front();
          if (want.cnr !== cnr_q8_i || want.lvl !== quality_level_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: cnr exp %0d got %0d, level exp %0d got %0d",
                       want.cnr, cnr_q8_i, want.lvl, quality_level_i);
          end
        end
      end
    end
  end

endmodule

// ===== sim/carrier_to_noise_estimator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carrier_to_noise_estimator_test
// Drives readings through the estimator under every register setting, with
// random sender bursts and receiver stalls; the checker scores each result.
// ----------------------------------------------------------------------------
module carrier_to_noise_estimator_test;
  import cne_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [23:0] raw_signal_i;
  logic        out_valid_o, out_ready_i;
  logic signed [15:0] cnr_q8_o;
  logic [1:0]  quality_level_o;

  // Mirror of the register file, for the checker.
  logic kind_q, lvl_en_q;
  int   fail_count, pending;

  carrier_to_noise_estimator u_dut (.*);

  cne_checker u_checker (
    .clk_i, .rst_ni,
    .kind_i(kind_q), .lvl_en_i(lvl_en_q),
    .in_valid_i, .in_ready_i(in_ready_o), .raw_signal_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .cnr_q8_i(cnr_q8_o), .quality_level_i(quality_level_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: alternate stretches of random stalls and full-rate draining.
  initial begin
    int mode;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Write one register through setup and access phases; pipeline must be empty.
  task automatic write_reg(input reg_idx_e idx, input logic val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CHANNEL_KIND) kind_q = val;
    else lvl_en_q = val;
  endtask

  // Hold valid and payload until the beat is taken.
  task automatic send_reading(input logic [23:0] raw);
    @(posedge clk_i);
    in_valid_i   <= 1'b1;
    raw_signal_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
  endtask

  // Back-to-back beats inside a burst: keep valid high between beats.
  task automatic send_burst(input int count, input logic kind);
    logic [23:0] r;
    for (int i = 0; i < count; i++) begin
      r = random_reading(kind);
      in_valid_i   <= 1'b1;
      raw_signal_i <= r;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [23:0] random_reading(input logic kind);
    case ($urandom_range(0, 4))
      0:       return 24'($urandom_range(0, 24'hFFFFFF));
      1:       return 24'($urandom_range(0, 255));
      2:       return kind ? {8'($urandom_range(0, 255)),
                              16'($urandom_range(16'h1000, 16'hB0FF))}
                           : 24'($urandom_range(0, 24'hFFFF));
      3:       return 24'($urandom_range(24'h400000, 24'h600000));
      default: return 24'(1) << $urandom_range(0, 23);
    endcase
  endfunction

  // Drain the pipeline before touching the registers.
  task automatic wait_idle;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    int sent, n;
    sent = 0;
    while (sent < count) begin
      n = $urandom_range(1, 24);
      send_burst(n, kind_q);
      sent += n;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  logic [23:0] directed[$] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h540000,
                               24'h540001, 24'h53FFFF, 24'h800000, 24'h000100,
                               24'h001000, 24'h0010FF, 24'h0011FF, 24'h0FFFFF,
                               24'h00AFFF, 24'h00B000, 24'hAAB0FF, 24'h005800,
                               24'h00A123, 24'h555555, 24'hAAAAAA, 24'h002000};

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; raw_signal_i = '0;
    kind_q = 1'b1; lvl_en_q = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings first, then every combination of the two registers.
    foreach (directed[i]) send_reading(directed[i]);
    wait_idle();
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_CHANNEL_KIND, s[0]);
      write_reg(REG_LEVEL_ENABLE, s[1]);
      foreach (directed[i]) send_reading(directed[i]);
      random_phase(150);
      // Pause until every result is back, then resume.
      wait_idle();
      random_phase(130);
      wait_idle();
    end

    repeat (200) begin
      @(posedge clk_i);
      if (pending == 0) break;
    end
    if (pending == 0 && fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cne_pkg.sv
rtl/carrier_to_noise_estimator.sv
rtl/cne_checker.sv
sim/cne_checker.sv
sim/carrier_to_noise_estimator_test.sv
